// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk and off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen at a rising clk edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// File: src/cxs_pkg.sv
// ----------------------------------------------------------------------------
// cxs_pkg
// widths, matrix coefficients and channel codes of the xyY to sRGB converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cxs_pkg;

  // fraction bits of the internal fixed-point values
  localparam int FRAC = 20;

  // input channel
  localparam int CH_W = 16;
  localparam int IN_W = 3 * CH_W;
  localparam logic [CH_W:0] CH_FULL = 17'd65535;
  localparam logic [CH_W-1:0] LUM_RND = 16'h7FFF;

  // luminance and tristimulus widths
  localparam int Y_W  = FRAC + 1;
  localparam int XQ_W = 36;
  localparam int XL_W = 18;

  // matrix stage widths
  localparam int COEF_W = 23;
  localparam int PP_W   = 45;
  localparam int SUM_W  = 62;
  localparam int R_W    = SUM_W - FRAC;
  localparam int RN_W   = R_W + FRAC;
  localparam int RQ_W   = FRAC + 1;

  localparam logic [FRAC:0]   ONE20 = 21'h100000;
  localparam logic [FRAC-1:0] HALF  = 20'h80000;

  // output channel codes
  localparam int NUM_CH = 3;
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  // D65 XYZ to linear sRGB, Q.20, rows r g b, columns X Y Z
  localparam logic signed [COEF_W-1:0] MTX [NUM_CH][3] = '{
    '{23'sd3397863,  -23'sd1611807, -23'sd522748},
    '{-23'sd1016349, 23'sd1967140,  23'sd43575},
    '{23'sd58346,    -23'sd213937,  23'sd1108581}
  };

endpackage

// File: src/cxs_div.sv
// ----------------------------------------------------------------------------
// cxs_div
// pipelined restoring divider, one quotient bit per stage, floor(num / den)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cxs_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 16,
  parameter int Q_W   = 36
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r   [Q_W-1];
  logic [DEN_W-1:0] den_r   [Q_W-1];
  logic [Q_W-1:0]   quo_r   [Q_W];
  logic [NUM_W-1:0] rem_in  [Q_W];
  logic [DEN_W-1:0] den_in  [Q_W];
  logic [Q_W-1:0]   quo_in  [Q_W];
  logic [CW-1:0]    dsh     [Q_W];
  logic [NUM_W-1:0] rem_nxt [Q_W];
  logic [Q_W-1:0]   quo_nxt [Q_W];
  logic [Q_W-1:0]   take;

  // stage inputs: first stage from the ports, the rest from the stage before
  always_comb begin
    rem_in[0] = num_i;
    den_in[0] = den_i;
    quo_in[0] = '0;
    for (int j = 1; j < Q_W; j++) begin
      rem_in[j] = rem_r[j-1];
      den_in[j] = den_r[j-1];
      quo_in[j] = quo_r[j-1];
    end
  end

  // one trial subtract per stage, msb first
  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      dsh[j]     = CW'(den_in[j]) << (Q_W - 1 - j);
      take[j]    = CW'(rem_in[j]) >= dsh[j];
      rem_nxt[j] = take[j] ? NUM_W'(CW'(rem_in[j]) - dsh[j]) : rem_in[j];
      quo_nxt[j] = quo_in[j] | (Q_W'(take[j]) << (Q_W - 1 - j));
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < Q_W - 1; j++) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= den_in[j];
      end
      for (int j = 0; j < Q_W; j++) begin
        quo_r[j] <= quo_nxt[j];
      end
    end
  end

  assign quo_o = quo_r[Q_W-1];

endmodule

// File: src/cxs_gamma.sv
// ----------------------------------------------------------------------------
// cxs_gamma
// sRGB transfer curve by table lookup with linear interpolation, six stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cxs_gamma #(
  parameter int GAMMA_TABLE_DEPTH = 1024,
  parameter int DUTY_BITS         = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 clr_i,
  input  logic [cxs_pkg::FRAC:0] lin_i,
  output logic [DUTY_BITS-1:0] duty_o
);

  import cxs_pkg::*;

  localparam int IDX_W = $clog2(GAMMA_TABLE_DEPTH + 1);
  localparam int POS_W = FRAC + IDX_W;
  localparam int ENT_W = FRAC + 1;
  localparam int GM_W  = ENT_W + DUTY_BITS;
  localparam int RD_W  = GM_W + 1 - FRAC;
  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(GAMMA_TABLE_DEPTH);
  localparam logic [DUTY_BITS-1:0] MAX_DUTY = '1;
  localparam longint unsigned ONE30     = 64'd1 << 30;
  localparam longint unsigned ONE20_64  = 64'd1 << FRAC;
  localparam longint unsigned GAMMA_OFS = 64'd59055800;

  // rounded Q.30 product
  function automatic longint unsigned mul30(input longint unsigned a,
                                            input longint unsigned b);
    return (a * b + (ONE30 >> 1)) >> 30;
  endfunction

  // curve value at table point idx / depth, Q.20
  function automatic logic [ENT_W-1:0] gamma_at(input int unsigned idx);
    longint unsigned i, d, cq, lo, hi, mid, t2, t4, t8, t12, r2, r4, r5, g30, g20;
    i = 64'(idx);
    d = 64'(GAMMA_TABLE_DEPTH);
    if (i * 64'd10000000 <= 64'd31308 * d) begin
      g20 = (64'd1292 * (i << FRAC) + 64'd50 * d) / (100 * GAMMA_TABLE_DEPTH);
    end else begin
      cq = ((i << 30) + d / 2) / GAMMA_TABLE_DEPTH;
      lo = 64'd0;
      hi = ONE30;
      // twelfth root by bisection
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        t2  = mul30(mid, mid);
        t4  = mul30(t2, t2);
        t8  = mul30(t4, t4);
        t12 = mul30(t8, t4);
        if (t12 <= cq) lo = mid;
        else hi = mid - 64'd1;
      end
      r2  = mul30(lo, lo);
      r4  = mul30(r2, r2);
      r5  = mul30(r4, lo);
      g30 = (64'd1055 * r5 + 64'd500) / 1000;
      g30 = (g30 > GAMMA_OFS) ? g30 - GAMMA_OFS : 64'd0;
      g20 = (g30 + 64'd512) >> 10;
    end
    if (g20 > ONE20_64) g20 = ONE20_64;
    return g20[ENT_W-1:0];
  endfunction

  // curve table, one entry per point plus the end point
  logic [ENT_W-1:0] tab_w [GAMMA_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= GAMMA_TABLE_DEPTH; gi++) begin : g_tab
    localparam logic [ENT_W-1:0] GV = gamma_at(gi);
    assign tab_w[gi] = GV;
  end

  logic [POS_W-1:0]   pos_r;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   nidx;
  logic [ENT_W-1:0]   lo_r, hi_r, a_r, g_r;
  logic [FRAC-1:0]    fr2_r;
  logic               neg_r;
  logic [ENT_W-1:0]   diff;
  logic [ENT_W+FRAC-1:0] prod_r;
  logic [ENT_W+FRAC:0]   prod_rnd;
  logic [ENT_W-1:0]   step;
  logic [GM_W-1:0]    gm_r;
  logic [GM_W:0]      gm_rnd;
  logic [RD_W-1:0]    rd;
  logic [DUTY_BITS-1:0] duty_r;

  assign idx  = pos_r[POS_W-1:FRAC];
  assign nidx = (idx == LAST_IDX) ? idx : idx + 1'b1;
  assign diff = (hi_r < lo_r) ? lo_r - hi_r : hi_r - lo_r;
  assign prod_rnd = (ENT_W + FRAC + 1)'(prod_r) + (ENT_W + FRAC + 1)'(HALF);
  assign step     = ENT_W'(prod_rnd[ENT_W+FRAC:FRAC]);
  assign gm_rnd   = (GM_W + 1)'(gm_r) + (GM_W + 1)'(HALF);
  assign rd       = gm_rnd[GM_W:FRAC];

  always_ff @(posedge clk) begin
    if (en) begin
      // table position
      pos_r  <= POS_W'(lin_i) * POS_W'(GAMMA_TABLE_DEPTH);
      // neighbor entries
      lo_r   <= tab_w[idx];
      hi_r   <= tab_w[nidx];
      fr2_r  <= pos_r[FRAC-1:0];
      // fractional share of the step
      a_r    <= lo_r;
      neg_r  <= hi_r < lo_r;
      prod_r <= (ENT_W + FRAC)'(diff) * (ENT_W + FRAC)'(fr2_r);
      // interpolated curve value
      g_r    <= neg_r ? a_r - step : a_r + step;
      // scale to duty range
      gm_r   <= GM_W'(g_r) * GM_W'(MAX_DUTY);
      // round, saturate, blank invalid items
      if (clr_i) begin
        duty_r <= '0;
      end else if (rd > RD_W'(MAX_DUTY)) begin
        duty_r <= MAX_DUTY;
      end else begin
        duty_r <= rd[DUTY_BITS-1:0];
      end
    end
  end

  assign duty_o = duty_r;

endmodule

// File: src/cie_xy_to_srgb_duty.sv
// ----------------------------------------------------------------------------
// cie_xy_to_srgb_duty
// CIE xyY chromaticity plus luminance to gamma-corrected sRGB duty cycles
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per color, tdata holds chroma_x [15:0], chroma_y [31:16]
//           and luminance [47:32], all Q0.16 with 65535 as full scale
//   out_* : one item per input item, tdata holds red, green and blue duty of
//           DUTY_BITS each from the low end, tuser flags an invalid coordinate
//   An item with chroma_y zero or x plus y above one gives zero duties and
//   tuser set.
//   The pipeline has 72 register stages. The depth is set by the two
//   bit-serial pipelined dividers (36 stages for X and Z, 21 for the
//   rescale) plus the matrix, clip and six-stage gamma lookup. One item is
//   taken per cycle while out_tready is high.
//   The whole pipeline advances together: when the output holds an item and
//   out_tready is low every stage freezes and in_tready drops, nothing lost.
//   Synchronous reset clears all valid bits; the gamma table is constant and
//   needs no fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cie_xy_to_srgb_duty #(
  parameter int DUTY_BITS         = 16,
  parameter int GAMMA_TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // chroma_x, chroma_y, luminance
  input  logic [cxs_pkg::IN_W-1:0]             in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // red_duty, green_duty, blue_duty, zero pad
  output logic [((3*DUTY_BITS+7)/8)*8-1:0]     out_tdata,
  // coordinate_invalid
  output logic [0:0]                           out_tuser
);

  import cxs_pkg::*;

  localparam int OUT_W = ((NUM_CH * DUTY_BITS + 7) / 8) * 8;
  localparam int P_DX  = 2 + XQ_W;
  localparam int P_ND  = P_DX + 6;
  localparam int P_DR  = P_ND + RQ_W;
  localparam int G_LAT = 6;
  localparam int LAT   = P_DR + G_LAT + 1;

  logic              adv;
  logic [LAT-1:0]    vld_r;
  logic [LAT-1:0]    inv_r;
  logic              inv_nxt;

  logic [CH_W-1:0]   cx_r, cy_r, lum_r;
  logic [CH_W-1:0]   cx2_r, cy2_r, w2_r, hf2_r;
  logic [Y_W-1:0]    y2_r;
  logic [XQ_W-1:0]   nx3_r, nz3_r;
  logic [CH_W-1:0]   cy3_r;
  logic [Y_W-1:0]    y3_r;
  logic [Y_W-1:0]    y_dly_r [XQ_W];

  logic [FRAC:0]     s1;
  logic [CH_W:0]     s2;
  logic [Y_W-1:0]    y_nxt;

  logic [XQ_W-1:0]   xq, zq;

  logic signed [PP_W-1:0]  p_xl_r [NUM_CH];
  logic signed [PP_W-1:0]  p_xh_r [NUM_CH];
  logic signed [PP_W-1:0]  p_y_r  [NUM_CH];
  logic signed [PP_W-1:0]  p_zl_r [NUM_CH];
  logic signed [PP_W-1:0]  p_zh_r [NUM_CH];
  logic signed [SUM_W-1:0] pa_r   [NUM_CH];
  logic signed [SUM_W-1:0] pc_r   [NUM_CH];
  logic signed [SUM_W-1:0] sum_r  [NUM_CH];
  logic [SUM_W-1:0]        rnd    [NUM_CH];
  logic [R_W-1:0]          lin_r  [NUM_CH];
  logic [R_W-1:0]          lin4_r [NUM_CH];
  logic [R_W-1:0]          mx_nxt, mx_r;
  logic                    big_r;
  logic [RN_W-1:0]         num_r  [NUM_CH];
  logic [R_W-1:0]          den_r  [NUM_CH];
  logic [RQ_W-1:0]         lin_q  [NUM_CH];
  logic [DUTY_BITS-1:0]    duty   [NUM_CH];

  // whole pipeline steps unless a finished item waits at the output
  assign adv       = !vld_r[LAT-1] || out_tready;
  assign in_tready = adv;

  // coordinate check on the incoming item
  assign inv_nxt = (in_tdata[2*CH_W-1:CH_W] == '0) ||
                   (({1'b0, in_tdata[CH_W-1:0]} + {1'b0, in_tdata[2*CH_W-1:CH_W]}) > CH_FULL);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // invalid flag travels with the item
  always_ff @(posedge clk) begin
    if (adv) begin
      inv_r <= {inv_r[LAT-2:0], inv_nxt};
    end
  end

  // Y = round(lum * 2^20 / 65535), folded division by 2^16 - 1
  always_comb begin
    s1    = (FRAC + 1)'({lum_r, 4'b0}) + (FRAC + 1)'(LUM_RND);
    s2    = (CH_W + 1)'(s1[FRAC:CH_W]) + (CH_W + 1)'(s1[CH_W-1:0]);
    y_nxt = Y_W'({lum_r, 4'b0}) + Y_W'(s1[FRAC:CH_W]) + Y_W'(s2 >= CH_FULL);
  end

  // input register, luminance scale, numerators
  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r  <= in_tdata[CH_W-1:0];
      cy_r  <= in_tdata[2*CH_W-1:CH_W];
      lum_r <= in_tdata[3*CH_W-1:2*CH_W];

      cx2_r <= cx_r;
      cy2_r <= cy_r;
      w2_r  <= CH_W'(CH_FULL) - cx_r - cy_r;
      hf2_r <= cy_r >> 1;
      y2_r  <= y_nxt;

      nx3_r <= XQ_W'((XQ_W + 1)'(cx2_r) * (XQ_W + 1)'(y2_r) + (XQ_W + 1)'(hf2_r));
      nz3_r <= XQ_W'((XQ_W + 1)'(w2_r) * (XQ_W + 1)'(y2_r) + (XQ_W + 1)'(hf2_r));
      cy3_r <= cy2_r;
      y3_r  <= y2_r;

      y_dly_r[0] <= y3_r;
      for (int k = 1; k < XQ_W; k++) begin
        y_dly_r[k] <= y_dly_r[k-1];
      end
    end
  end

  // X and Z dividers
  cxs_div #(.NUM_W(XQ_W), .DEN_W(CH_W), .Q_W(XQ_W)) u_div_x (
    .clk(clk), .en(adv), .num_i(nx3_r), .den_i(cy3_r), .quo_o(xq)
  );

  cxs_div #(.NUM_W(XQ_W), .DEN_W(CH_W), .Q_W(XQ_W)) u_div_z (
    .clk(clk), .en(adv), .num_i(nz3_r), .den_i(cy3_r), .quo_o(zq)
  );

  // rounding of each matrix row
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rnd[c] = sum_r[c] + SUM_W'(HALF);
    end
  end

  // largest linear component
  always_comb begin
    mx_nxt = lin_r[CH_R];
    if (lin_r[CH_G] > mx_nxt) mx_nxt = lin_r[CH_G];
    if (lin_r[CH_B] > mx_nxt) mx_nxt = lin_r[CH_B];
  end

  // matrix products, partial sums, clip, rescale operands
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NUM_CH; c++) begin
        p_xl_r[c] <= $signed(PP_W'({1'b0, xq[XL_W-1:0]})) * PP_W'(MTX[c][0]);
        p_xh_r[c] <= $signed(PP_W'({1'b0, xq[XQ_W-1:XL_W]})) * PP_W'(MTX[c][0]);
        p_y_r[c]  <= $signed(PP_W'({1'b0, y_dly_r[XQ_W-1]})) * PP_W'(MTX[c][1]);
        p_zl_r[c] <= $signed(PP_W'({1'b0, zq[XL_W-1:0]})) * PP_W'(MTX[c][2]);
        p_zh_r[c] <= $signed(PP_W'({1'b0, zq[XQ_W-1:XL_W]})) * PP_W'(MTX[c][2]);

        pa_r[c] <= (SUM_W'(p_xh_r[c]) <<< XL_W) + SUM_W'(p_xl_r[c]);
        pc_r[c] <= (SUM_W'(p_zh_r[c]) <<< XL_W) + SUM_W'(p_zl_r[c]) + SUM_W'(p_y_r[c]);

        sum_r[c] <= pa_r[c] + pc_r[c];

        if (sum_r[c][SUM_W-1] || sum_r[c] == '0) begin
          lin_r[c] <= '0;
        end else begin
          lin_r[c] <= rnd[c][SUM_W-1:FRAC];
        end

        lin4_r[c] <= lin_r[c];

        // above full scale divides by the max, else divide by one
        if (big_r) begin
          num_r[c] <= {lin4_r[c], FRAC'(0)} + RN_W'(mx_r >> 1);
          den_r[c] <= mx_r;
        end else begin
          num_r[c] <= {lin4_r[c], FRAC'(0)};
          den_r[c] <= R_W'(ONE20);
        end
      end
      mx_r  <= mx_nxt;
      big_r <= mx_nxt > R_W'(ONE20);
    end
  end

  // rescale dividers and gamma lookup per channel
  for (genvar gc = 0; gc < NUM_CH; gc++) begin : g_ch
    cxs_div #(.NUM_W(RN_W), .DEN_W(R_W), .Q_W(RQ_W)) u_div_r (
      .clk(clk), .en(adv), .num_i(num_r[gc]), .den_i(den_r[gc]), .quo_o(lin_q[gc])
    );

    cxs_gamma #(.GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH), .DUTY_BITS(DUTY_BITS)) u_gamma (
      .clk(clk), .en(adv), .clr_i(inv_r[LAT-2]), .lin_i(lin_q[gc]), .duty_o(duty[gc])
    );
  end

  // output channel
  assign out_tvalid = vld_r[LAT-1];
  assign out_tuser  = inv_r[LAT-1];
  assign out_tdata  = OUT_W'({duty[CH_B], duty[CH_G], duty[CH_R]});

  `ASSERT_CLK(a_in_enters, in_tvalid && in_tready |=> vld_r[0], "accepted item missing in pipeline")
  `ASSERT_CLK(a_stall_holds, !adv |=> $stable(vld_r), "valid bits moved during a stall")
  `ASSERT_CLK(a_rescale_range, vld_r[P_DR] |-> lin_q[CH_R] <= RQ_W'(ONE20) && lin_q[CH_G] <= RQ_W'(ONE20) && lin_q[CH_B] <= RQ_W'(ONE20), "rescaled component above full scale")
  `ASSERT_NEVER(a_invalid_zero, out_tvalid && out_tuser[0] && out_tdata != '0, "invalid coordinate gave nonzero duty")

endmodule
